@@ hdl/refkb_pkg.sv @@
// shared types and constants for the reference-counted key buffer table
package refkb_pkg;

  localparam int unsigned DEV_W  = 32;
  localparam int unsigned INO_W  = 64;
  localparam int unsigned REFS_W = 16;
  // slot index carried on the chain, wide enough for tables of up to 256 entries
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned STAT_W = 3;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  typedef enum logic [STAT_W-1:0] {
    STAT_HIT      = 3'd0,
    STAT_ALLOC    = 3'd1,
    STAT_NOSPACE  = 3'd2,
    STAT_HELD     = 3'd3,
    STAT_RELEASED = 3'd4,
    STAT_NOTFOUND = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    UPD_ALLOC = 2'd0,
    UPD_SET   = 2'd1,
    UPD_FREE  = 2'd2
  } upd_op_e;

  // search token walking down the row of cells
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [REFS_W-1:0] hit_refs;
    logic              free_seen;
    logic [IDX_W-1:0]  free_idx;
  } token_t;

  // write-back command broadcast to all cells
  typedef struct packed {
    logic              en;
    upd_op_e           op;
    logic [IDX_W-1:0]  idx;
    logic [REFS_W-1:0] refs;
  } upd_t;

endpackage

@@ hdl/refkb_cell.sv @@
// one table entry: key compare, token hand-off and write-back
module refkb_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  refkb_pkg::token_t                 tok_i,
  output refkb_pkg::token_t                 tok_o,
  input  logic [refkb_pkg::DEV_W-1:0]       dev_i,
  input  logic [refkb_pkg::INO_W-1:0]       ino_i,
  input  refkb_pkg::upd_t                   upd_i
);
  import refkb_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic              valid_q;
  logic [DEV_W-1:0]  dev_q;
  logic [INO_W-1:0]  ino_q;
  logic [REFS_W-1:0] refs_q;
  token_t            tok_q, tok_d;
  logic              match;
  logic              upd_me;

  assign match  = valid_q && (dev_q == dev_i) && (ino_q == ino_i);
  assign upd_me = upd_i.en && (upd_i.idx == MY_IDX);

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.hit && match) begin
      tok_d.hit      = 1'b1;
      tok_d.hit_idx  = MY_IDX;
      tok_d.hit_refs = refs_q;
    end
    if (tok_i.valid && !tok_i.free_seen && !valid_q) begin
      tok_d.free_seen = 1'b1;
      tok_d.free_idx  = MY_IDX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      if (upd_me) begin
        case (upd_i.op)
          UPD_ALLOC: valid_q <= 1'b1;
          UPD_FREE:  valid_q <= 1'b0;
          default:   valid_q <= valid_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_me) begin
      case (upd_i.op)
        UPD_ALLOC: begin
          dev_q  <= dev_i;
          ino_q  <= ino_i;
          refs_q <= upd_i.refs;
        end
        UPD_SET:   refs_q <= upd_i.refs;
        default:   refs_q <= refs_q;
      endcase
    end
  end

  assign tok_o = tok_q;

endmodule

@@ hdl/refkb_ctrl.sv @@
// request sequencer: key capture, token launch, decision and write-back
module refkb_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func_i,
  input  logic [refkb_pkg::DEV_W-1:0]   device_i,
  input  logic [refkb_pkg::INO_W-1:0]   inode_number_i,
  output logic [refkb_pkg::DEV_W-1:0]   key_dev_o,
  output logic [refkb_pkg::INO_W-1:0]   key_ino_o,
  output refkb_pkg::token_t             tok_head_o,
  input  refkb_pkg::token_t             tok_tail_i,
  output refkb_pkg::upd_t               upd_o,
  output logic                          done_o,
  output logic [refkb_pkg::STAT_W-1:0]  status_o,
  output logic [refkb_pkg::SLOT_W-1:0]  slot_o,
  output logic [refkb_pkg::REFS_W-1:0]  ref_count_o
);
  import refkb_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_e;

  state_e            state_q;
  logic              inj_q;
  logic              func_q;
  logic [DEV_W-1:0]  dev_q;
  logic [INO_W-1:0]  ino_q;
  logic              done_q;
  status_e           stat_q, stat_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [REFS_W-1:0] refs_q, refs_d;
  upd_t              upd_q, upd_d;
  logic [REFS_W-1:0] dec_refs;

  assign busy = (state_q != S_IDLE);

  assign dec_refs = (tok_tail_i.hit_refs != '0) ? tok_tail_i.hit_refs - 1'b1 : '0;

  always_comb begin
    stat_d = STAT_NOSPACE;
    idx_d  = '0;
    refs_d = '0;
    upd_d  = '0;
    if (!func_q) begin
      if (tok_tail_i.hit) begin
        stat_d    = STAT_HIT;
        idx_d     = tok_tail_i.hit_idx;
        refs_d    = (tok_tail_i.hit_refs == REFS_MAX) ? REFS_MAX
                                                      : tok_tail_i.hit_refs + 1'b1;
        upd_d.en  = 1'b1;
        upd_d.op  = UPD_SET;
      end else if (tok_tail_i.free_seen) begin
        stat_d    = STAT_ALLOC;
        idx_d     = tok_tail_i.free_idx;
        refs_d    = REFS_W'(1);
        upd_d.en  = 1'b1;
        upd_d.op  = UPD_ALLOC;
      end
    end else begin
      if (!tok_tail_i.hit) begin
        stat_d = STAT_NOTFOUND;
      end else if (dec_refs != '0) begin
        stat_d   = STAT_HELD;
        idx_d    = tok_tail_i.hit_idx;
        refs_d   = dec_refs;
        upd_d.en = 1'b1;
        upd_d.op = UPD_SET;
      end else begin
        stat_d   = STAT_RELEASED;
        idx_d    = tok_tail_i.hit_idx;
        upd_d.en = 1'b1;
        upd_d.op = UPD_FREE;
      end
    end
    upd_d.idx  = idx_d;
    upd_d.refs = refs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      inj_q   <= 1'b0;
      done_q  <= 1'b0;
      upd_q   <= '0;
    end else begin
      inj_q    <= 1'b0;
      done_q   <= 1'b0;
      upd_q.en <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            inj_q   <= 1'b1;
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (tok_tail_i.valid) begin
            done_q  <= 1'b1;
            upd_q   <= upd_d;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      func_q <= func_i;
      dev_q  <= device_i;
      ino_q  <= inode_number_i;
    end
    if (busy && tok_tail_i.valid) begin
      stat_q <= stat_d;
      idx_q  <= idx_d;
      refs_q <= refs_d;
    end
  end

  always_comb begin
    tok_head_o       = '0;
    tok_head_o.valid = inj_q;
  end

  assign key_dev_o   = dev_q;
  assign key_ino_o   = ino_q;
  assign upd_o       = upd_q;
  assign done_o      = done_q;
  assign status_o    = stat_q;
  assign slot_o      = idx_q[SLOT_W-1:0];
  assign ref_count_o = refs_q;

endmodule

@@ hdl/refcounted_key_buffer_table.sv @@
// top level: reference-counted key buffer table built as a row of entry cells
//
// one request at a time: a get or put is taken when start is high and busy is
// low, and its result shows on status_o, slot_o and ref_count_o for exactly one
// cycle with done_o high; the receiver cannot stall and must take it then.
// from accept, the request passes the launch register, the token register of
// each cell in turn and the done register before its result cycle; the next
// one can be taken in that result cycle, and not before. the search token walks
// the row of cells one cell per cycle so that the lowest matching slot and the
// lowest free slot are found in order. the write-back to the chosen cell lands
// on the edge that ends the result cycle. reset empties the table at once
// through the per-entry valid bits; no clearing pass.
module refcounted_key_buffer_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func_i,
  input  logic [refkb_pkg::DEV_W-1:0]   device_i,
  input  logic [refkb_pkg::INO_W-1:0]   inode_number_i,
  output logic                          done_o,
  output logic [refkb_pkg::STAT_W-1:0]  status_o,
  output logic [refkb_pkg::SLOT_W-1:0]  slot_o,
  output logic [refkb_pkg::REFS_W-1:0]  ref_count_o
);
  import refkb_pkg::*;

  // token links: tok[0] enters the first cell, tok[TABLE_ENTRIES] leaves the last
  token_t            tok [TABLE_ENTRIES+1];
  upd_t              upd;
  logic [DEV_W-1:0]  key_dev;
  logic [INO_W-1:0]  key_ino;

  // sequencer: holds the key steady during the walk and decides at the tail
  refkb_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .device_i       (device_i),
    .inode_number_i (inode_number_i),
    .key_dev_o      (key_dev),
    .key_ino_o      (key_ino),
    .tok_head_o     (tok[0]),
    .tok_tail_i     (tok[TABLE_ENTRIES]),
    .upd_o          (upd),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .ref_count_o    (ref_count_o)
  );

  // row of entry cells; each compares its own key and passes the token on
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    refkb_cell #(
      .INDEX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1]),
      .dev_i  (key_dev),
      .ino_i  (key_ino),
      .upd_i  (upd)
    );
  end

endmodule
